// ===== hdl/ffa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

    localparam int ENTRIES          = 256;
    localparam int STORE_BYTES      = 1048576;
    localparam int MAX_RECORD_BYTES = 4095;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int OFF_W   = $clog2(STORE_BYTES);
    localparam int END_W   = OFF_W + 1;
    localparam int BYTES_W = 12;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 3;

    localparam logic [BYTES_W-1:0] MAX_REQ   = BYTES_W'(MAX_RECORD_BYTES);
    localparam logic [END_W-1:0]   STORE_END = END_W'(STORE_BYTES);
    localparam logic [CNT_W-1:0]   TABLE_CAP = CNT_W'(ENTRIES);

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd2;

    localparam logic [STAT_W-1:0] ST_REUSED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_OK        = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_VALID = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [OFF_W-1:0]   offset;
        logic [BYTES_W-1:0] bytes;
        logic               valid;
        logic               has_next;
        logic [IDX_W-1:0]   next;
    } t_entry;

    typedef struct packed {
        logic               ge;
        logic               gt;
        logic               over;
        logic [BYTES_W-1:0] rem;
        logic [END_W-1:0]   sum;
    } t_fit;

endpackage

`default_nettype wire

// ===== hdl/first_fit_free_list_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// First-fit extent allocator. Pulse start while busy is low; exactly one result word
// follows on o_strobe for one cycle, and the receiver cannot stall it. Release and
// look up pass through S_ENT_RD and S_ENT_CHK before the registered strobe; a bad
// index is answered in the next cycle and busy never rises for it. Allocate reads
// one free-list entry per S_WALK and S_CHK through the single table read port, then
// reuses the first hole that fits (S_WPREV, S_WSPLIT, S_WCUR as needed) or appends,
// walking at most 256 entries. busy falls in the cycle the result appears, so a new
// command may be taken while the result is shown.

module first_fit_free_list_allocator (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire [ffa_pkg::KIND_W-1:0]  i_kind,
    input  wire [ffa_pkg::BYTES_W-1:0] i_request_bytes,
    input  wire [7:0]                  i_entry_index,
    output logic                       o_strobe,
    output logic [7:0]                 o_result_index,
    output logic [19:0]                o_extent_offset,
    output logic [ffa_pkg::BYTES_W-1:0] o_extent_bytes,
    output logic [ffa_pkg::STAT_W-1:0] o_status
);
    import ffa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_WALK, S_CHK, S_WPREV, S_WSPLIT, S_WCUR, S_APPEND, S_ENT_RD, S_ENT_CHK
    } t_state;

    t_state r_state, n_state;

    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [BYTES_W-1:0] r_req, n_req;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_used, n_used;
    logic               r_head_vld, n_head_vld;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [END_W-1:0]   r_end, n_end;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [CNT_W-1:0]   r_steps, n_steps;
    logic               r_have_prev, n_have_prev;
    logic [IDX_W-1:0]   r_prev, n_prev;
    t_entry             r_prev_ent, n_prev_ent;
    t_entry             r_cur_ent, n_cur_ent;
    logic               r_split, n_split;
    logic [IDX_W-1:0]   r_new_idx, n_new_idx;
    logic               r_new_hv, n_new_hv;
    logic [IDX_W-1:0]   r_new_h, n_new_h;
    logic [BYTES_W-1:0] r_rem, n_rem;
    logic [OFF_W-1:0]   r_rem_off, n_rem_off;

    logic               r_strobe, n_strobe;
    logic [IDX_W-1:0]   r_o_idx, n_o_idx;
    logic [OFF_W-1:0]   r_o_off, n_o_off;
    logic [BYTES_W-1:0] r_o_bytes, n_o_bytes;
    logic [STAT_W-1:0]  r_o_stat, n_o_stat;

    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    t_entry             mem_wdata, rd;

    logic [END_W-1:0]   fit_base;
    logic [BYTES_W-1:0] fit_bytes;
    t_fit               fit;

    logic               h1_vld;
    logic [IDX_W-1:0]   h1;

    ffa_table u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    ffa_fit u_fit (
        .i_base  (fit_base),
        .i_bytes (fit_bytes),
        .i_req   (r_req),
        .o_fit   (fit)
    );

    assign busy = (r_state != S_IDLE);

    always_comb begin
        fit_base  = r_end;
        fit_bytes = rd.bytes;
        if (r_state == S_CHK) begin
            fit_base = {1'b0, rd.offset};
        end
        h1_vld = r_have_prev ? r_head_vld : rd.has_next;
        h1     = r_have_prev ? r_head : rd.next;
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_req       = r_req;
        n_idx       = r_idx;
        n_used      = r_used;
        n_head_vld  = r_head_vld;
        n_head      = r_head;
        n_end       = r_end;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_have_prev = r_have_prev;
        n_prev      = r_prev;
        n_prev_ent  = r_prev_ent;
        n_cur_ent   = r_cur_ent;
        n_split     = r_split;
        n_new_idx   = r_new_idx;
        n_new_hv    = r_new_hv;
        n_new_h     = r_new_h;
        n_rem       = r_rem;
        n_rem_off   = r_rem_off;
        n_strobe    = 1'b0;
        n_o_idx     = r_o_idx;
        n_o_off     = r_o_off;
        n_o_bytes   = r_o_bytes;
        n_o_stat    = r_o_stat;
        mem_we      = 1'b0;
        mem_waddr   = r_cur;
        mem_wdata   = r_cur_ent;
        mem_re      = 1'b0;
        mem_raddr   = r_cur;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind      = i_kind;
                    n_req       = (i_request_bytes > MAX_REQ) ? MAX_REQ : i_request_bytes;
                    n_idx       = i_entry_index;
                    n_cur       = r_head;
                    n_steps     = '0;
                    n_have_prev = 1'b0;
                    if (i_kind == KIND_ALLOC) begin
                        n_state = r_head_vld ? S_WALK : S_APPEND;
                    end else if ({1'b0, i_entry_index} >= r_used) begin
                        n_strobe  = 1'b1;
                        n_o_idx   = i_entry_index;
                        n_o_off   = '0;
                        n_o_bytes = '0;
                        n_o_stat  = ST_BAD_INDEX;
                    end else begin
                        n_state = S_ENT_RD;
                    end
                end
            end
            S_WALK: begin
                if (r_steps == TABLE_CAP || {1'b0, r_cur} >= r_used) begin
                    n_state = S_APPEND;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_cur_ent = rd;
                if (!rd.valid && fit.ge) begin
                    if (fit.gt && r_used == TABLE_CAP) begin
                        n_strobe  = 1'b1;
                        n_o_idx   = '0;
                        n_o_off   = '0;
                        n_o_bytes = '0;
                        n_o_stat  = ST_FULL;
                        n_state   = S_IDLE;
                    end else begin
                        n_split   = fit.gt;
                        n_rem     = fit.rem;
                        n_rem_off = fit.sum[OFF_W-1:0];
                        n_new_idx = r_used[IDX_W-1:0];
                        n_new_hv  = h1_vld;
                        n_new_h   = h1;
                        if (fit.gt) begin
                            n_head_vld = 1'b1;
                            n_head     = r_used[IDX_W-1:0];
                            n_used     = r_used + 1'b1;
                        end else begin
                            n_head_vld = h1_vld;
                            n_head     = h1;
                        end
                        if (r_have_prev) begin
                            n_state = S_WPREV;
                        end else begin
                            n_state = fit.gt ? S_WSPLIT : S_WCUR;
                        end
                    end
                end else begin
                    n_have_prev = 1'b1;
                    n_prev      = r_cur;
                    n_prev_ent  = rd;
                    n_cur       = rd.next;
                    n_steps     = r_steps + 1'b1;
                    n_state     = rd.has_next ? S_WALK : S_APPEND;
                end
            end
            S_WPREV: begin
                mem_we             = 1'b1;
                mem_waddr          = r_prev;
                mem_wdata          = r_prev_ent;
                mem_wdata.has_next = r_cur_ent.has_next;
                mem_wdata.next     = r_cur_ent.next;
                n_state            = r_split ? S_WSPLIT : S_WCUR;
            end
            S_WSPLIT: begin
                mem_we             = 1'b1;
                mem_waddr          = r_new_idx;
                mem_wdata.offset   = r_rem_off;
                mem_wdata.bytes    = r_rem;
                mem_wdata.valid    = 1'b0;
                mem_wdata.has_next = r_new_hv;
                mem_wdata.next     = r_new_h;
                n_state            = S_WCUR;
            end
            S_WCUR: begin
                mem_we             = 1'b1;
                mem_waddr          = r_cur;
                mem_wdata.offset   = r_cur_ent.offset;
                mem_wdata.bytes    = r_req;
                mem_wdata.valid    = 1'b1;
                mem_wdata.has_next = 1'b0;
                mem_wdata.next     = '0;
                n_strobe           = 1'b1;
                n_o_idx            = r_cur;
                n_o_off            = r_cur_ent.offset;
                n_o_bytes          = r_req;
                n_o_stat           = ST_REUSED;
                n_state            = S_IDLE;
            end
            S_APPEND: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (r_used == TABLE_CAP || fit.over) begin
                    n_o_idx   = '0;
                    n_o_off   = '0;
                    n_o_bytes = '0;
                    n_o_stat  = ST_FULL;
                end else begin
                    mem_we             = 1'b1;
                    mem_waddr          = r_used[IDX_W-1:0];
                    mem_wdata.offset   = r_end[OFF_W-1:0];
                    mem_wdata.bytes    = r_req;
                    mem_wdata.valid    = 1'b1;
                    mem_wdata.has_next = 1'b0;
                    mem_wdata.next     = '0;
                    n_used             = r_used + 1'b1;
                    n_end              = fit.sum;
                    n_o_idx            = r_used[IDX_W-1:0];
                    n_o_off            = r_end[OFF_W-1:0];
                    n_o_bytes          = r_req;
                    n_o_stat           = ST_OK;
                end
            end
            S_ENT_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx;
                n_state   = S_ENT_CHK;
            end
            S_ENT_CHK: begin
                n_strobe = 1'b1;
                n_o_idx  = r_idx;
                n_state  = S_IDLE;
                if (!rd.valid) begin
                    n_o_off   = '0;
                    n_o_bytes = '0;
                    n_o_stat  = ST_NOT_VALID;
                end else begin
                    n_o_off   = rd.offset;
                    n_o_bytes = rd.bytes;
                    n_o_stat  = ST_OK;
                    if (r_kind == KIND_RELEASE) begin
                        mem_we             = 1'b1;
                        mem_waddr          = r_idx;
                        mem_wdata          = rd;
                        mem_wdata.valid    = 1'b0;
                        mem_wdata.has_next = r_head_vld;
                        mem_wdata.next     = r_head;
                        n_head_vld         = 1'b1;
                        n_head             = r_idx;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_head_vld <= 1'b0;
            r_head     <= '0;
            r_end      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_head_vld <= n_head_vld;
            r_head     <= n_head;
            r_end      <= n_end;
            r_strobe   <= n_strobe;
        end
        r_kind      <= n_kind;
        r_req       <= n_req;
        r_idx       <= n_idx;
        r_cur       <= n_cur;
        r_steps     <= n_steps;
        r_have_prev <= n_have_prev;
        r_prev      <= n_prev;
        r_prev_ent  <= n_prev_ent;
        r_cur_ent   <= n_cur_ent;
        r_split     <= n_split;
        r_new_idx   <= n_new_idx;
        r_new_hv    <= n_new_hv;
        r_new_h     <= n_new_h;
        r_rem       <= n_rem;
        r_rem_off   <= n_rem_off;
        r_o_idx     <= n_o_idx;
        r_o_off     <= n_o_off;
        r_o_bytes   <= n_o_bytes;
        r_o_stat    <= n_o_stat;
    end

    assign o_strobe        = r_strobe;
    assign o_result_index  = r_o_idx;
    assign o_extent_offset = r_o_off;
    assign o_extent_bytes  = r_o_bytes;
    assign o_status        = r_o_stat;

    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= TABLE_CAP)
        else $error("entry count above table size");

    a_head_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_vld |-> ({1'b0, r_head} < r_used))
        else $error("free list head points past used entries");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !(i_kind != KIND_ALLOC && {1'b0, i_entry_index} >= r_used))
            |=> busy)
        else $error("accepted command did not raise busy");

endmodule

`default_nettype wire

// ===== hdl/ffa_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffa_table (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [ffa_pkg::IDX_W-1:0]  i_waddr,
    input  ffa_pkg::t_entry           i_wdata,
    input  wire                       i_re,
    input  wire [ffa_pkg::IDX_W-1:0]  i_raddr,
    output ffa_pkg::t_entry           o_rdata
);
    import ffa_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/ffa_fit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffa_fit (
    input  wire [ffa_pkg::END_W-1:0]   i_base,
    input  wire [ffa_pkg::BYTES_W-1:0] i_bytes,
    input  wire [ffa_pkg::BYTES_W-1:0] i_req,
    output ffa_pkg::t_fit              o_fit
);
    import ffa_pkg::*;

    always_comb begin
        o_fit.ge   = i_bytes >= i_req;
        o_fit.gt   = i_bytes > i_req;
        o_fit.rem  = i_bytes - i_req;
        o_fit.sum  = i_base + END_W'(i_req);
        o_fit.over = o_fit.sum > STORE_END;
    end

endmodule

`default_nettype wire
